[rtl/core/allm_pkg.sv]
// shared constants, codes and types of the array linked list manager
package allm_pkg;

  localparam int LIST_SLOTS_DEF = 64;

  localparam int MODE_W     = 2;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INS_FRONT = 2'd0;
  localparam mode_t MODE_INS_AFTER = 2'd1;
  localparam mode_t MODE_DEL_FRONT = 2'd2;
  localparam mode_t MODE_DEL_AFTER = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_NO_SUCC   = 3'd4;

  // strobes from the sequencer to the slot memories
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic value_we;
  } mem_ctl_t;

endpackage

[rtl/core/allm_req_if.sv]
// request channel: operation mode, search key and value to store
interface allm_req_if;
  logic                               valid;
  logic                               ready;
  logic [allm_pkg::MODE_W-1:0]        mode;
  logic signed [allm_pkg::DATA_W-1:0] match_value;
  logic signed [allm_pkg::DATA_W-1:0] item_value;

  modport source (output valid, mode, match_value, item_value, input ready);
  modport sink   (input valid, mode, match_value, item_value, output ready);
endinterface

[rtl/core/allm_rsp_if.sv]
// response channel: status and slot touched
interface allm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [allm_pkg::STATUS_W-1:0]   status;
  logic [allm_pkg::SLOT_OUT_W-1:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

[rtl/core/allm_mem.sv]
// link and value memories of the slot pool, one write and one registered read each
module allm_mem #(
  parameter int LIST_SLOTS = allm_pkg::LIST_SLOTS_DEF,
  localparam int SLOT_W = $clog2(LIST_SLOTS),
  localparam int LINK_W = SLOT_W + 1
) (
  input  logic                        clk,
  input  allm_pkg::mem_ctl_t          mem_ctl,
  input  logic [SLOT_W-1:0]           rd_addr,
  input  logic [SLOT_W-1:0]           link_waddr,
  input  logic [LINK_W-1:0]           link_wdata,
  input  logic [SLOT_W-1:0]           value_waddr,
  input  logic [allm_pkg::DATA_W-1:0] value_wdata,
  output logic [LINK_W-1:0]           link_q,
  output logic [allm_pkg::DATA_W-1:0] value_q
);

  logic [LINK_W-1:0]           link_mem  [LIST_SLOTS];
  logic [allm_pkg::DATA_W-1:0] value_mem [LIST_SLOTS];

  always_ff @(posedge clk) begin
    if (mem_ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (mem_ctl.rd_en) begin
      link_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    if (mem_ctl.rd_en) begin
      value_q <= value_mem[rd_addr];
    end
  end

endmodule

[rtl/core/allm_ctrl.sv]
// request sequencer: init sweep, list walk and relinking of head and free chains
module allm_ctrl #(
  parameter int LIST_SLOTS = allm_pkg::LIST_SLOTS_DEF,
  localparam int SLOT_W = $clog2(LIST_SLOTS),
  localparam int LINK_W = SLOT_W + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [allm_pkg::MODE_W-1:0]     in_mode,
  input  logic [allm_pkg::DATA_W-1:0]     in_match,
  input  logic [allm_pkg::DATA_W-1:0]     in_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [allm_pkg::STATUS_W-1:0]   res_status,
  output logic [allm_pkg::SLOT_OUT_W-1:0] res_slot,
  output allm_pkg::mem_ctl_t              mem_ctl,
  output logic [SLOT_W-1:0]               rd_addr,
  output logic [SLOT_W-1:0]               link_waddr,
  output logic [LINK_W-1:0]               link_wdata,
  output logic [SLOT_W-1:0]               value_waddr,
  output logic [allm_pkg::DATA_W-1:0]     value_wdata,
  input  logic [LINK_W-1:0]               link_q,
  input  logic [allm_pkg::DATA_W-1:0]     value_q
);

  localparam logic [LINK_W-1:0] NULL_LINK = '1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LIST_SLOTS - 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_IF   = 4'd3;
  localparam logic [3:0] S_DF   = 4'd4;
  localparam logic [3:0] S_IA1  = 4'd5;
  localparam logic [3:0] S_IA2  = 4'd6;
  localparam logic [3:0] S_DA1  = 4'd7;
  localparam logic [3:0] S_DA2  = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  logic [3:0]                     state_r, state_nxt;
  logic [SLOT_W-1:0]              init_r, init_nxt;
  logic [LINK_W-1:0]              head_r, head_nxt;
  logic [LINK_W-1:0]              free_r, free_nxt;
  logic [SLOT_W-1:0]              cur_r, cur_nxt;
  logic [SLOT_W-1:0]              hit_r, hit_nxt;
  logic [LINK_W-1:0]              nxt_r, nxt_nxt;
  logic [allm_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic [allm_pkg::DATA_W-1:0]    key_r, key_nxt;
  logic [allm_pkg::DATA_W-1:0]    item_r, item_nxt;
  logic [allm_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;

  function automatic logic is_slot(input logic [LINK_W-1:0] v);
    return v < LINK_W'(LIST_SLOTS);
  endfunction

  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    head_nxt    = head_r;
    free_nxt    = free_r;
    cur_nxt     = cur_r;
    hit_nxt     = hit_r;
    nxt_nxt     = nxt_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    item_nxt    = item_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    mem_ctl     = '0;
    rd_addr     = cur_r;
    link_waddr  = cur_r;
    link_wdata  = free_r;
    value_waddr = free_r[SLOT_W-1:0];
    value_wdata = item_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      S_INIT: begin
        // chain every slot into the free list, last one ends it
        mem_ctl.link_we = 1'b1;
        link_waddr      = init_r;
        if (init_r == LAST_SLOT) begin
          link_wdata = NULL_LINK;
          state_nxt  = S_IDLE;
        end else begin
          link_wdata = {1'b0, init_r} + LINK_W'(1);
          init_nxt   = init_r + SLOT_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt   = in_mode;
          key_nxt    = in_match;
          item_nxt   = in_item;
          status_nxt = allm_pkg::ST_OK;
          slot_nxt   = '0;
          cur_nxt    = head_r[SLOT_W-1:0];
          rd_addr    = head_r[SLOT_W-1:0];
          case (in_mode)
            allm_pkg::MODE_INS_FRONT: begin
              if (!is_slot(free_r)) begin
                status_nxt = allm_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = free_r[SLOT_W-1:0];
                state_nxt     = S_IF;
              end
            end
            allm_pkg::MODE_INS_AFTER: begin
              if (!is_slot(head_r)) begin
                status_nxt = allm_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else if (!is_slot(free_r)) begin
                status_nxt = allm_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                state_nxt     = S_SRCH;
              end
            end
            allm_pkg::MODE_DEL_FRONT: begin
              if (!is_slot(head_r)) begin
                status_nxt = allm_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                state_nxt     = S_DF;
              end
            end
            default: begin
              if (!is_slot(head_r)) begin
                status_nxt = allm_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                mem_ctl.rd_en = 1'b1;
                state_nxt     = S_SRCH;
              end
            end
          endcase
        end
      end
      S_SRCH: begin
        // read data belongs to cur_r; the next node's read goes out straight from link_q
        if (value_q == key_r) begin
          hit_nxt = cur_r;
          nxt_nxt = link_q;
          if (mode_r == allm_pkg::MODE_INS_AFTER) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = free_r[SLOT_W-1:0];
            state_nxt     = S_IA1;
          end else if (!is_slot(link_q)) begin
            status_nxt = allm_pkg::ST_NO_SUCC;
            state_nxt  = S_RESP;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = link_q[SLOT_W-1:0];
            state_nxt     = S_DA1;
          end
        end else if (is_slot(link_q)) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = link_q[SLOT_W-1:0];
          cur_nxt       = link_q[SLOT_W-1:0];
        end else begin
          status_nxt = allm_pkg::ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end
      end
      S_IF: begin
        mem_ctl.value_we = 1'b1;
        mem_ctl.link_we  = 1'b1;
        link_waddr       = free_r[SLOT_W-1:0];
        link_wdata       = head_r;
        head_nxt         = free_r;
        free_nxt         = link_q;
        slot_nxt         = free_r[SLOT_W-1:0];
        state_nxt        = S_RESP;
      end
      S_DF: begin
        mem_ctl.link_we = 1'b1;
        link_waddr      = head_r[SLOT_W-1:0];
        link_wdata      = free_r;
        free_nxt        = head_r;
        head_nxt        = link_q;
        slot_nxt        = head_r[SLOT_W-1:0];
        state_nxt       = S_RESP;
      end
      S_IA1: begin
        // new node takes the matched node's successor
        mem_ctl.value_we = 1'b1;
        mem_ctl.link_we  = 1'b1;
        link_waddr       = free_r[SLOT_W-1:0];
        link_wdata       = nxt_r;
        free_nxt         = link_q;
        slot_nxt         = free_r[SLOT_W-1:0];
        state_nxt        = S_IA2;
      end
      S_IA2: begin
        mem_ctl.link_we = 1'b1;
        link_waddr      = hit_r;
        link_wdata      = {1'b0, slot_r};
        state_nxt       = S_RESP;
      end
      S_DA1: begin
        // unlink the successor of the matched node
        mem_ctl.link_we = 1'b1;
        link_waddr      = hit_r;
        link_wdata      = link_q;
        state_nxt       = S_DA2;
      end
      S_DA2: begin
        mem_ctl.link_we = 1'b1;
        link_waddr      = nxt_r[SLOT_W-1:0];
        link_wdata      = free_r;
        free_nxt        = nxt_r;
        slot_nxt        = nxt_r[SLOT_W-1:0];
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_status = status_r;
  assign res_slot   = allm_pkg::SLOT_OUT_W'(slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      head_r  <= NULL_LINK;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    hit_r    <= hit_nxt;
    nxt_r    <= nxt_nxt;
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    item_r   <= item_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

endmodule

[rtl/core/array_linked_list_manager.sv]
// Singly linked list kept in a pool of LIST_SLOTS slots with a free chain, one request at a
// time. After reset the block chains every slot into the free list and takes no request
// during that sweep. Insert front and delete front read the free or head slot on acceptance
// and relink it in S_IF or S_DF before the response state; the searching modes walk the list
// one node per cycle through the read port of the link and value memories and, on a match,
// relink through S_IA1 and S_IA2 or S_DA1 and S_DA2. Early status results (empty, full) go
// straight to the response state without a memory read. A new request is accepted once the
// previous result has moved into the output register.
module array_linked_list_manager #(
  parameter int LIST_SLOTS = allm_pkg::LIST_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  allm_req_if.sink   in_ch,
  allm_rsp_if.source out_ch
);

  localparam int SLOT_W = $clog2(LIST_SLOTS);
  localparam int LINK_W = SLOT_W + 1;

  allm_pkg::mem_ctl_t              mem_ctl;
  logic [SLOT_W-1:0]               rd_addr;
  logic [SLOT_W-1:0]               link_waddr;
  logic [LINK_W-1:0]               link_wdata;
  logic [SLOT_W-1:0]               value_waddr;
  logic [allm_pkg::DATA_W-1:0]     value_wdata;
  logic [LINK_W-1:0]               link_q;
  logic [allm_pkg::DATA_W-1:0]     value_q;
  logic                            res_valid;
  logic                            res_ready;
  logic [allm_pkg::STATUS_W-1:0]   res_status;
  logic [allm_pkg::SLOT_OUT_W-1:0] res_slot;

  logic                            out_valid_r;
  logic [allm_pkg::STATUS_W-1:0]   out_status_r;
  logic [allm_pkg::SLOT_OUT_W-1:0] out_slot_r;

  allm_ctrl #(.LIST_SLOTS(LIST_SLOTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_mode     (in_ch.mode),
    .in_match    (in_ch.match_value),
    .in_item     (in_ch.item_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_status  (res_status),
    .res_slot    (res_slot),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .value_waddr (value_waddr),
    .value_wdata (value_wdata),
    .link_q      (link_q),
    .value_q     (value_q)
  );

  allm_mem #(.LIST_SLOTS(LIST_SLOTS)) u_mem (
    .clk         (clk),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .value_waddr (value_waddr),
    .value_wdata (value_wdata),
    .link_q      (link_q),
    .value_q     (value_q)
  );

  // output word register, refilled as it drains
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

endmodule

[sim/allm_list_checker.sv]
`timescale 1ns / 1ps
// response scoreboard for the linked list manager: mirrors the slot pool and checks each word
module allm_list_checker (
  input  logic clk,
  input  logic rst_n,
  allm_req_if  req,
  allm_rsp_if  rsp,
  output int   pending_cnt,
  output int   err_cnt
);

  localparam int SLOTS = allm_pkg::LIST_SLOTS_DEF;

  typedef logic [6:0] link_t;
  localparam link_t NIL = 7'h7f;

  typedef struct packed {
    allm_pkg::status_t               status;
    logic [allm_pkg::SLOT_OUT_W-1:0] slot;
  } rsp_word_t;

  link_t                       next_of [SLOTS];
  logic [allm_pkg::DATA_W-1:0] val_of  [SLOTS];
  link_t                       head_idx;
  link_t                       free_idx;
  rsp_word_t                   rsp_due_q [$];
  int                          n_err = 0;

  assign err_cnt = n_err;

  function automatic void clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      next_of[i] = (i == SLOTS - 1) ? NIL : link_t'(i + 1);
      val_of[i]  = '0;
    end
    head_idx = NIL;
    free_idx = '0;
  endfunction

  // first node holding key, walk bounded by the pool size
  function automatic link_t find_first(logic [allm_pkg::DATA_W-1:0] key);
    link_t cur;
    int    steps;
    cur   = head_idx;
    steps = 0;
    while (cur != NIL && steps < SLOTS) begin
      if (val_of[cur] == key) return cur;
      cur = next_of[cur];
      steps++;
    end
    return NIL;
  endfunction

  function automatic link_t take_free();
    link_t s;
    s        = free_idx;
    free_idx = next_of[s];
    return s;
  endfunction

  function automatic void give_free(link_t s);
    next_of[s] = free_idx;
    free_idx   = s;
  endfunction

  function automatic rsp_word_t apply_list_op(allm_pkg::mode_t m,
                                              logic [allm_pkg::DATA_W-1:0] key,
                                              logic [allm_pkg::DATA_W-1:0] item);
    rsp_word_t r;
    link_t     hit;
    link_t     s;
    r.status = allm_pkg::ST_OK;
    r.slot   = '0;
    case (m)
      allm_pkg::MODE_INS_FRONT: begin
        if (free_idx == NIL) begin
          r.status = allm_pkg::ST_FULL;
        end else begin
          s          = take_free();
          val_of[s]  = item;
          next_of[s] = head_idx;
          head_idx   = s;
          r.slot     = s[allm_pkg::SLOT_OUT_W-1:0];
        end
      end
      allm_pkg::MODE_INS_AFTER: begin
        // empty wins over full, full wins over a failed search
        if (head_idx == NIL) begin
          r.status = allm_pkg::ST_EMPTY;
        end else if (free_idx == NIL) begin
          r.status = allm_pkg::ST_FULL;
        end else begin
          hit = find_first(key);
          if (hit == NIL) begin
            r.status = allm_pkg::ST_NOT_FOUND;
          end else begin
            s            = take_free();
            val_of[s]    = item;
            next_of[s]   = next_of[hit];
            next_of[hit] = s;
            r.slot       = s[allm_pkg::SLOT_OUT_W-1:0];
          end
        end
      end
      allm_pkg::MODE_DEL_FRONT: begin
        if (head_idx == NIL) begin
          r.status = allm_pkg::ST_EMPTY;
        end else begin
          s        = head_idx;
          head_idx = next_of[s];
          give_free(s);
          r.slot   = s[allm_pkg::SLOT_OUT_W-1:0];
        end
      end
      default: begin
        if (head_idx == NIL) begin
          r.status = allm_pkg::ST_EMPTY;
        end else begin
          hit = find_first(key);
          if (hit == NIL) begin
            r.status = allm_pkg::ST_NOT_FOUND;
          end else if (next_of[hit] == NIL) begin
            r.status = allm_pkg::ST_NO_SUCC;
          end else begin
            s            = next_of[hit];
            next_of[hit] = next_of[s];
            give_free(s);
            r.slot       = s[allm_pkg::SLOT_OUT_W-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns list checker: %s", $realtime, msg);
    n_err++;
  endtask

  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst_n) begin
      clear_pool();
      rsp_due_q.delete();
    end else begin
      // a response is never for the request taken at the same edge
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word: status %0d slot %0d",
                                    rsp.status, rsp.slot));
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
          end
          if (rsp.slot !== want.slot) begin
            report_mismatch($sformatf("slot %0d, want %0d", rsp.slot, want.slot));
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        rsp_due_q.push_back(apply_list_op(req.mode, req.match_value, req.item_value));
      end
    end
    pending_cnt <= rsp_due_q.size();
  end

endmodule

[sim/tb_array_linked_list_manager.sv]
`timescale 1ns / 1ps
// testbench top for the linked list manager: clock, reset, request traffic and verdict
module tb_array_linked_list_manager;

  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASES      = 16;
  localparam int PHASE_LEN   = 100;
  localparam int TAIL_CYCLES = 100;

  logic                        clk = 1'b0;
  logic                        rst_n;
  int                          pending_cnt;
  int                          err_cnt;
  int                          idle_cycles = 0;
  bit                          quiet = 1'b0;
  logic [allm_pkg::DATA_W-1:0] hot_vals [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                                32'hffff_ffff, 32'h0000_5a5a, 32'h1234_5678};

  allm_req_if req_ch ();
  allm_rsp_if rsp_ch ();

  array_linked_list_manager i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  allm_list_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .pending_cnt (pending_cnt),
    .err_cnt     (err_cnt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly values likely to sit in the list, sometimes anything
  function automatic logic [allm_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return hot_vals[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  task automatic send_req(allm_pkg::mode_t m, logic [allm_pkg::DATA_W-1:0] key,
                          logic [allm_pkg::DATA_W-1:0] item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.match_value <= key;
    req_ch.item_value  <= item;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  initial begin
    allm_pkg::mode_t m;
    int              ins_pct;
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= allm_pkg::MODE_INS_FRONT;
    req_ch.match_value <= '0;
    req_ch.item_value  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // delete front, delete after and insert after on an empty list
    send_req(allm_pkg::MODE_DEL_FRONT, 32'h0, 32'h0);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'h0, 32'h0);
    send_req(allm_pkg::MODE_INS_AFTER, 32'h0, 32'h5);
    // build -1, 0, max, min
    send_req(allm_pkg::MODE_INS_FRONT, 32'hffff_ffff, 32'h8000_0000);
    send_req(allm_pkg::MODE_INS_FRONT, 32'h0, 32'h7fff_ffff);
    send_req(allm_pkg::MODE_INS_FRONT, 32'h8000_0000, 32'h0);
    send_req(allm_pkg::MODE_INS_FRONT, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(allm_pkg::MODE_INS_AFTER, 32'hffff_ffff, 32'h1);
    send_req(allm_pkg::MODE_INS_AFTER, 32'h0000_5a5a, 32'h2);
    // insert after the tail node, then remove it again
    send_req(allm_pkg::MODE_INS_AFTER, 32'h8000_0000, 32'hffff_ffff);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'h8000_0000, 32'h0);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'h8000_0000, 32'h0);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'hffff_ffff, 32'h0);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'h0000_0309, 32'h0);
    // duplicate key: only the first match counts
    send_req(allm_pkg::MODE_INS_FRONT, 32'h0, 32'h0);
    send_req(allm_pkg::MODE_DEL_AFTER, 32'h0, 32'hffff_ffff);
    send_req(allm_pkg::MODE_INS_AFTER, 32'h0, 32'h7fff_ffff);
    repeat (6) send_req(allm_pkg::MODE_DEL_FRONT, 32'hffff_ffff, 32'hffff_ffff);
    wait_drained();

    // fill, mixed, drain and back-to-back mixed phases; fill phases run into a full pool
    for (int p = 0; p < PHASES; p++) begin
      quiet   = (p % 4 == 3);
      ins_pct = (p % 4 == 0) ? 85 : (p % 4 == 2) ? 20 : 50;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          m = $urandom_range(0, 1) ? allm_pkg::MODE_INS_AFTER : allm_pkg::MODE_INS_FRONT;
        end else begin
          m = $urandom_range(0, 1) ? allm_pkg::MODE_DEL_AFTER : allm_pkg::MODE_DEL_FRONT;
        end
        send_req(m, pick_value(), pick_value());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_array_linked_list_manager: done, clean");
    end else begin
      $display("tb_array_linked_list_manager: done, errors");
    end
    $finish;
  end

  // response side back-pressure, one draw per word
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_array_linked_list_manager: done, errors");
        $finish;
      end
    end
  end

endmodule

[files.f]
rtl/core/allm_pkg.sv
rtl/core/allm_req_if.sv
rtl/core/allm_rsp_if.sv
rtl/core/allm_mem.sv
rtl/core/allm_ctrl.sv
rtl/core/array_linked_list_manager.sv
sim/allm_list_checker.sv
sim/tb_array_linked_list_manager.sv
